/* hw/rtl/vrs_pkg.sv */
// ----------------------------------------------------------------------------
// vrs_pkg
// Shared types for the variation region scalar: controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package vrs_pkg;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch a new axis word and classify it
        logic div_step;  // one restoring division step
        logic mul;       // fold the axis factor into the running product
        logic out_load;  // move the product to the output and restart at 1.0
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_div;  // the axis factor comes from a ramp division
        logic emit;      // this axis closes the region
    } t_dp_sts;

endpackage

/* hw/rtl/variation_region_scalar_core.sv */
// ----------------------------------------------------------------------------
// variation_region_scalar_core
// Font-variation region scalar: per-axis tent factor folded into a product.
// ----------------------------------------------------------------------------
// Each input word is one axis of a region; the block takes one axis at a
// time and takes no new axis until it is through with the last one. An axis
// with a ramp factor goes through the radix-2 restoring divider, which
// produces one quotient bit per cycle; an axis whose factor is 0 or 1.0
// skips the division. On the last axis, or after MAX_AXES axes without a
// last mark, the product is moved to the output register, a move that waits
// while the output is stalled; the running product then restarts at 1.0
// (1 << FRAC_BITS).
module variation_region_scalar_core
    import vrs_pkg::*;
#(
    parameter int FRAC_BITS = 14,
    parameter int MAX_AXES  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [15:0]  i_span_start,
    input  logic signed [15:0]  i_span_peak,
    input  logic signed [15:0]  i_span_end,
    input  logic signed [15:0]  i_coord,
    input  logic                i_last_axis,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [FRAC_BITS:0]  o_region_weight
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    vrs_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    vrs_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_AXES  (MAX_AXES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_span_start    (i_span_start),
        .i_span_peak     (i_span_peak),
        .i_span_end      (i_span_end),
        .i_coord         (i_coord),
        .i_last_axis     (i_last_axis),
        .o_region_weight (o_region_weight)
    );

endmodule

/* hw/rtl/vrs_datapath.sv */
// ----------------------------------------------------------------------------
// vrs_datapath
// Axis classification, radix-2 restoring divider for the ramp factor,
// running product multiplier and the output register.
// ----------------------------------------------------------------------------
module vrs_datapath
    import vrs_pkg::*;
#(
    parameter int FRAC_BITS = 14,
    parameter int MAX_AXES  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    input  logic signed [15:0]     i_span_start,
    input  logic signed [15:0]     i_span_peak,
    input  logic signed [15:0]     i_span_end,
    input  logic signed [15:0]     i_coord,
    input  logic                   i_last_axis,
    output logic [FRAC_BITS:0]     o_region_weight
);

    localparam int FW  = FRAC_BITS + 1;
    localparam int AXW = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
    localparam logic [FW-1:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

    logic [FW-1:0]       r_prod, n_prod;
    logic [FW-1:0]       r_fac, n_fac;
    logic [15:0]         r_rem, n_rem;
    logic [15:0]         r_div, n_div;
    logic                r_need_div, n_need_div;
    logic                r_emit, n_emit;
    logic [AXW-1:0]      r_axis, n_axis;
    logic [FW-1:0]       r_out, n_out;

    logic signed [16:0]  a, p, z, x;
    logic                malformed, outside;
    logic [16:0]         rem2, rem_sub;
    logic                ge;
    logic [2*FW-1:0]     mul_full;

    // sign-extended operands for the ramp differences
    assign a = {i_span_start[15], i_span_start};
    assign p = {i_span_peak[15], i_span_peak};
    assign z = {i_span_end[15], i_span_end};
    assign x = {i_coord[15], i_coord};

    // tent checks: a malformed tent forces a factor of one, a coordinate outside it zero
    assign malformed = (a > p) || (p > z) || ((a < 0) && (z > 0) && (p != 0))
                       || (p == 0);
    assign outside   = (x < a) || (x > z);

    // one restoring division step
    assign rem2    = {r_rem, 1'b0};
    assign ge      = rem2 >= {1'b0, r_div};
    assign rem_sub = rem2 - {1'b0, r_div};

    assign mul_full = r_prod * r_fac;

    // next-value logic
    always_comb begin
        n_prod     = r_prod;
        n_fac      = r_fac;
        n_rem      = r_rem;
        n_div      = r_div;
        n_need_div = r_need_div;
        n_emit     = r_emit;
        n_axis     = r_axis;
        n_out      = r_out;
        if (i_cmd.load) begin
            n_need_div = 1'b0;
            n_rem      = '0;
            n_div      = '0;
            if (malformed) begin
                n_fac = ONE_FX;
            end else if (outside) begin
                n_fac = '0;
            end else if (x == p) begin
                n_fac = ONE_FX;
            end else if (x < p) begin
                n_fac      = '0;
                n_need_div = 1'b1;
                n_rem      = 16'(x - a);
                n_div      = 16'(p - a);
            end else begin
                n_fac      = '0;
                n_need_div = 1'b1;
                n_rem      = 16'(z - x);
                n_div      = 16'(z - p);
            end
            n_emit = i_last_axis || (r_axis == AXW'(MAX_AXES - 1));
            n_axis = n_emit ? '0 : r_axis + 1'b1;
        end
        if (i_cmd.div_step) begin
            n_rem = ge ? rem_sub[15:0] : rem2[15:0];
            n_fac = {r_fac[FW-2:0], ge};
        end
        if (i_cmd.mul) begin
            n_prod = mul_full[2*FRAC_BITS:FRAC_BITS];
        end
        if (i_cmd.out_load) begin
            n_out  = r_prod;
            n_prod = ONE_FX;
        end
    end

    // control-relevant state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod <= ONE_FX;
            r_axis <= '0;
        end else begin
            r_prod <= n_prod;
            r_axis <= n_axis;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_fac      <= n_fac;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_need_div <= n_need_div;
        r_emit     <= n_emit;
        r_out      <= n_out;
    end

    assign o_sts.need_div  = r_need_div;
    assign o_sts.emit      = r_emit;
    assign o_region_weight = r_out;

endmodule

/* hw/rtl/vrs_ctrl.sv */
// ----------------------------------------------------------------------------
// vrs_ctrl
// Sequencer for one axis at a time: accept, divide, multiply, and hand the
// region weight to the output register when the region closes.
// ----------------------------------------------------------------------------
module vrs_ctrl
    import vrs_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam int CW = $clog2(FRAC_BITS);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;
    logic            out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_DIV;
            ST_DIV: begin
                if (!i_sts.need_div || (r_cnt == '0)) n_state = ST_MUL;
            end
            ST_MUL:  n_state = i_sts.emit ? ST_EMIT : ST_IDLE;
            ST_EMIT: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and step counter
    always_comb begin
        o_cmd = '0;
        n_cnt = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = CW'(FRAC_BITS - 1);
                end
            end
            ST_DIV: begin
                if (i_sts.need_div) begin
                    o_cmd.div_step = 1'b1;
                    n_cnt          = r_cnt - 1'b1;
                end
            end
            ST_MUL:  o_cmd.mul = 1'b1;
            ST_EMIT: o_cmd.out_load = out_free;
            default: o_cmd = '0;
        endcase
    end

    // output word valid
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.out_load) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* hw/rtl/vrs_checker.sv */
// ----------------------------------------------------------------------------
// vrs_checker
// Port-level checks for the variation region scalar, bound to the top level.
// ----------------------------------------------------------------------------
module vrs_checker #(
    parameter int FRAC_BITS = 14
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [FRAC_BITS:0]  o_region_weight
);

    localparam logic [FRAC_BITS:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

    // a pending word is not dropped while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped under stall");

    // weight never exceeds 1.0
    a_weight_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_region_weight <= ONE_FX))
        else $error("region weight above 1.0");

    // one axis at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second axis accepted back to back");

    // reset leaves the block empty and ready
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind variation_region_scalar_core vrs_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_vrs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_region_weight (o_region_weight)
);
